/* rtl/multi_channel_integrating_debouncer_macros.svh */
// Assertion macros shared by the debouncer RTL.
`ifndef MULTI_CHANNEL_INTEGRATING_DEBOUNCER_MACROS_SVH
`define MULTI_CHANNEL_INTEGRATING_DEBOUNCER_MACROS_SVH

// Same-cycle implication, clocked on clk_i, quiet while in reset.
`define MCID_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("debouncer assertion failed");

// Next-cycle implication, clocked on clk_i, quiet while in reset.
`define MCID_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("debouncer assertion failed");

`endif

/* rtl/mcid_pkg.sv */
// Package: constants, register codes, state type and control structs of the debouncer.
package mcid_pkg;

  localparam int CHANNELS      = 40;
  localparam int COUNT_BITS    = 8;
  localparam int WORD_BITS     = CHANNELS;
  localparam int CFG_BITS      = 8;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 40;
  localparam int CH_BITS       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CMP_BITS      = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [CFG_BITS-1:0]  RST_COUNT_LIMIT = CFG_BITS'(1);
  localparam logic [CFG_BITS-1:0]  RST_ON_THRESH   = CFG_BITS'(1);
  localparam logic [CFG_BITS-1:0]  RST_OFF_THRESH  = CFG_BITS'(0);
  localparam logic [WORD_BITS-1:0] RST_ENABLE_MASK = 40'hFF_FFFF_FF01;
  localparam logic [WORD_BITS-1:0] RST_INVERT_MASK = 40'hC0_FFFF_FF01;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_COUNT_LIMIT = 3'd0,
    CFG_ON_THRESH   = 3'd1,
    CFG_OFF_THRESH  = 3'd2,
    CFG_ENABLE_MASK = 3'd3,
    CFG_INVERT_MASK = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_PUBLISH
  } mcid_state_e;

  typedef struct packed {
    logic               start;
    logic               rd_en;
    logic [CH_BITS-1:0] rd_addr;
    logic               load_out;
  } mcid_cmd_t;

  typedef struct packed {
    logic s1_valid;
  } mcid_status_t;

endpackage

/* rtl/mcid_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mcid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 40
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic                                          re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/mcid_ctrl.sv */
// Controller: sequences one channel read per cycle and hands the finished word to the output.
module mcid_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  mcid_pkg::mcid_status_t status_i,
  output mcid_pkg::mcid_cmd_t    cmd_o
);

  mcid_pkg::mcid_state_e             state_q, state_d;
  logic [mcid_pkg::CH_BITS-1:0]      ch_q, ch_d;
  logic                              out_valid_q, out_valid_d;
  logic                              last_ch;
  logic                              slot_free;

  assign last_ch   = (ch_q == mcid_pkg::CH_BITS'(mcid_pkg::CHANNELS - 1));
  assign slot_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mcid_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = mcid_pkg::ST_RUN;
        end
      end
      mcid_pkg::ST_RUN: begin
        if (last_ch) begin
          state_d = mcid_pkg::ST_PUBLISH;
        end
      end
      mcid_pkg::ST_PUBLISH: begin
        // wait for the last channel to retire and the output slot to empty
        if (!status_i.s1_valid && slot_free) begin
          state_d = mcid_pkg::ST_IDLE;
        end
      end
      default: state_d = mcid_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.rd_addr  = ch_q;
    in_ready_o     = 1'b0;
    unique case (state_q)
      mcid_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
      end
      mcid_pkg::ST_RUN: begin
        cmd_o.rd_en = 1'b1;
      end
      mcid_pkg::ST_PUBLISH: begin
        cmd_o.load_out = !status_i.s1_valid && slot_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    ch_d = ch_q;
    if (cmd_o.start) begin
      ch_d = '0;
    end else if (cmd_o.rd_en && !last_ch) begin
      ch_d = ch_q + 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mcid_pkg::ST_IDLE;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/mcid_datapath.sv */
// Datapath: configuration registers, counter RAM, level bits and the per-channel update unit.
module mcid_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mcid_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [mcid_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  input  logic [mcid_pkg::WORD_BITS-1:0]      raw_pins_i,
  input  mcid_pkg::mcid_cmd_t                 cmd_i,
  output mcid_pkg::mcid_status_t              status_o,
  output logic [mcid_pkg::WORD_BITS-1:0]      filtered_pins_o
);

  logic [mcid_pkg::CFG_BITS-1:0]   count_limit_q, on_thresh_q, off_thresh_q;
  logic [mcid_pkg::WORD_BITS-1:0]  enable_mask_q, invert_mask_q;
  logic [mcid_pkg::WORD_BITS-1:0]  pins_q;
  logic [mcid_pkg::WORD_BITS-1:0]  res_q, res_d;
  logic [mcid_pkg::WORD_BITS-1:0]  out_q;
  logic [mcid_pkg::CHANNELS-1:0]   valid_q, level_q;
  logic                            s1_valid_q;
  logic [mcid_pkg::CH_BITS-1:0]    s1_ch_q;

  logic [mcid_pkg::COUNT_BITS-1:0] rd_data;
  logic [mcid_pkg::COUNT_BITS-1:0] cnt, cnt_next;
  logic [mcid_pkg::CMP_BITS-1:0]   cnt_w, next_w, limit_w, cl_w, cmax_w;
  logic                            pin, en, lvl, wr_en;

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_limit_q <= mcid_pkg::RST_COUNT_LIMIT;
      on_thresh_q   <= mcid_pkg::RST_ON_THRESH;
      off_thresh_q  <= mcid_pkg::RST_OFF_THRESH;
      enable_mask_q <= mcid_pkg::RST_ENABLE_MASK;
      invert_mask_q <= mcid_pkg::RST_INVERT_MASK;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mcid_pkg::CFG_COUNT_LIMIT: count_limit_q <= cfg_wdata_i[mcid_pkg::CFG_BITS-1:0];
        mcid_pkg::CFG_ON_THRESH:   on_thresh_q   <= cfg_wdata_i[mcid_pkg::CFG_BITS-1:0];
        mcid_pkg::CFG_OFF_THRESH:  off_thresh_q  <= cfg_wdata_i[mcid_pkg::CFG_BITS-1:0];
        mcid_pkg::CFG_ENABLE_MASK: enable_mask_q <= cfg_wdata_i[mcid_pkg::WORD_BITS-1:0];
        mcid_pkg::CFG_INVERT_MASK: invert_mask_q <= cfg_wdata_i[mcid_pkg::WORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  mcid_ram #(
    .WIDTH (mcid_pkg::COUNT_BITS),
    .DEPTH (mcid_pkg::CHANNELS)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_ch_q),
    .wdata_i (cnt_next),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_addr),
    .rdata_o (rd_data)
  );

  // Update stage: one channel, with the counter read in the previous cycle
  always_comb begin
    pin     = pins_q[s1_ch_q];
    en      = enable_mask_q[s1_ch_q];
    cnt     = valid_q[s1_ch_q] ? rd_data : '0;
    cnt_w   = mcid_pkg::CMP_BITS'(cnt);
    cl_w    = mcid_pkg::CMP_BITS'(count_limit_q);
    cmax_w  = mcid_pkg::CMP_BITS'(mcid_pkg::COUNT_MAX);
    limit_w = (cl_w > cmax_w) ? cmax_w : cl_w;
    lvl     = level_q[s1_ch_q];
    if (pin) begin
      cnt_next = (cnt_w < limit_w) ? cnt + 1'b1 : cnt;
      next_w   = mcid_pkg::CMP_BITS'(cnt_next);
      if (next_w >= mcid_pkg::CMP_BITS'(on_thresh_q)) begin
        lvl = 1'b1;
      end
    end else begin
      cnt_next = (cnt != '0) ? cnt - 1'b1 : cnt;
      next_w   = mcid_pkg::CMP_BITS'(cnt_next);
      if (next_w <= mcid_pkg::CMP_BITS'(off_thresh_q)) begin
        lvl = 1'b0;
      end
    end
    wr_en = s1_valid_q && en;
  end

  always_comb begin
    res_d = res_q;
    if (cmd_i.start) begin
      res_d = '0;
    end else if (s1_valid_q) begin
      res_d[s1_ch_q] = en && (lvl ^ invert_mask_q[s1_ch_q]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      valid_q    <= '0;
      level_q    <= '0;
    end else begin
      s1_valid_q <= cmd_i.rd_en;
      if (wr_en) begin
        valid_q[s1_ch_q] <= 1'b1;
        level_q[s1_ch_q] <= lvl;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ch_q <= cmd_i.rd_addr;
    res_q   <= res_d;
    if (cmd_i.start) begin
      pins_q <= raw_pins_i;
    end
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  assign status_o.s1_valid = s1_valid_q;
  assign filtered_pins_o   = out_q;

endmodule

/* rtl/multi_channel_integrating_debouncer.sv */
// Top level: integrating debouncer over 40 channels with shared limits and masks.
// Flow: accept in idle, read-modify-write each channel in turn in the shared counter RAM,
//   then publish the word once the last update retires and the output slot is free.
// A new request is taken only after the previous one has been published.
// A finished result waits in the output register while the next request is taken.
// Reset: counters and levels read as zero, registers take their documented defaults.
`include "multi_channel_integrating_debouncer_macros.svh"

module multi_channel_integrating_debouncer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mcid_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [mcid_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [mcid_pkg::WORD_BITS-1:0]     raw_pins_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [mcid_pkg::WORD_BITS-1:0]     filtered_pins_o
);

  mcid_pkg::mcid_cmd_t    cmd;
  mcid_pkg::mcid_status_t status;

  mcid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mcid_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .raw_pins_i      (raw_pins_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .filtered_pins_o (filtered_pins_o)
  );

  `MCID_ASSERT_NEXT(a_start_reads_first, cmd.start, cmd.rd_en && cmd.rd_addr == '0)
  `MCID_ASSERT_IMP(a_no_overwrite, cmd.load_out, !out_valid_o || out_ready_i)
  `MCID_ASSERT_IMP(a_idle_quiet, in_ready_o, !status.s1_valid && !cmd.rd_en)

endmodule

/* tb/sv/multi_channel_integrating_debouncer_tb.sv */
// Self-checking testbench for the multi-channel integrating debouncer.
`timescale 1ns / 1ps

module multi_channel_integrating_debouncer_tb;

  localparam int CYCLE_LIMIT = 800000;
  localparam int PHASES = 12;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [mcid_pkg::CFG_IDX_BITS-1:0] CFG_IDX_UNUSED = 3'd7;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               cfg_we_i;
  logic [mcid_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [mcid_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i;
  logic                               in_valid_i;
  logic                               in_ready_o;
  logic [mcid_pkg::WORD_BITS-1:0]     raw_pins_i;
  logic                               out_valid_o;
  logic                               out_ready_i;
  logic [mcid_pkg::WORD_BITS-1:0]     filtered_pins_o;

  multi_channel_integrating_debouncer DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .raw_pins_i      (raw_pins_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .filtered_pins_o (filtered_pins_o)
  );

  // Shadow copy of the block's settings and per-channel state
  logic [mcid_pkg::CFG_BITS-1:0]   limit_reg;
  logic [mcid_pkg::CFG_BITS-1:0]   on_reg;
  logic [mcid_pkg::CFG_BITS-1:0]   off_reg;
  logic [mcid_pkg::WORD_BITS-1:0]  enable_reg;
  logic [mcid_pkg::WORD_BITS-1:0]  invert_reg;
  logic [mcid_pkg::COUNT_BITS-1:0] chan_count [mcid_pkg::CHANNELS];
  logic                            chan_level [mcid_pkg::CHANNELS];

  logic [mcid_pkg::WORD_BITS-1:0] pending_pins [$];
  logic [mcid_pkg::WORD_BITS-1:0] expected_filtered [$];

  int  queued_count;
  int  accepted_count;
  int  results_seen;
  int  error_count;
  int  settings_count;
  int  cycle_count;
  int  send_idle_pct;
  int  recv_idle_pct;
  int  hold_left;
  bit  held_off;
  bit  in_fire;
  logic [mcid_pkg::WORD_BITS-1:0] base_pins;

  // Advance every enabled channel by one sample and return the output word
  function automatic logic [mcid_pkg::WORD_BITS-1:0] debounce_word(
      logic [mcid_pkg::WORD_BITS-1:0] pins);
    logic [mcid_pkg::WORD_BITS-1:0] word;
    logic [mcid_pkg::CMP_BITS-1:0]  lim;
    logic [mcid_pkg::CMP_BITS-1:0]  cnt;
    word = '0;
    lim = (mcid_pkg::CMP_BITS'(limit_reg) > mcid_pkg::CMP_BITS'(mcid_pkg::COUNT_MAX))
        ? mcid_pkg::CMP_BITS'(mcid_pkg::COUNT_MAX) : mcid_pkg::CMP_BITS'(limit_reg);
    for (int ch = 0; ch < mcid_pkg::CHANNELS; ch++) begin
      if (enable_reg[ch]) begin
        cnt = mcid_pkg::CMP_BITS'(chan_count[ch]);
        if (pins[ch]) begin
          if (cnt < lim) cnt = cnt + 1'b1;
          if (cnt >= mcid_pkg::CMP_BITS'(on_reg)) chan_level[ch] = 1'b1;
        end else begin
          if (cnt != '0) cnt = cnt - 1'b1;
          if (cnt <= mcid_pkg::CMP_BITS'(off_reg)) chan_level[ch] = 1'b0;
        end
        chan_count[ch] = cnt[mcid_pkg::COUNT_BITS-1:0];
        word[ch] = chan_level[ch] ^ invert_reg[ch];
      end
    end
    return word;
  endfunction

  function automatic logic [mcid_pkg::WORD_BITS-1:0] rand_word();
    return mcid_pkg::WORD_BITS'({$urandom(), $urandom()});
  endfunction

  // Flip each bit of the base pattern with the given chance in percent
  function automatic logic [mcid_pkg::WORD_BITS-1:0] noisy_word(
      logic [mcid_pkg::WORD_BITS-1:0] base, int pct);
    logic [mcid_pkg::WORD_BITS-1:0] w;
    w = base;
    for (int b = 0; b < mcid_pkg::WORD_BITS; b++)
      if ($urandom_range(0, 99) < pct) w[b] = ~w[b];
    return w;
  endfunction

  function automatic logic [mcid_pkg::WORD_BITS-1:0] pick_mask();
    case ($urandom_range(0, 7))
      0: return '0;
      1, 2: return '1;
      default: return rand_word();
    endcase
  endfunction

  function automatic logic [mcid_pkg::CFG_BITS-1:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return mcid_pkg::CFG_BITS'($urandom_range(1, 16));
      default: return mcid_pkg::CFG_BITS'($urandom());
    endcase
  endfunction

  // Drive one register write and mirror it; called at a falling edge
  task automatic put_reg(logic [mcid_pkg::CFG_IDX_BITS-1:0] idx,
                         logic [mcid_pkg::CFG_DATA_BITS-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      mcid_pkg::CFG_COUNT_LIMIT: limit_reg  = data[mcid_pkg::CFG_BITS-1:0];
      mcid_pkg::CFG_ON_THRESH:   on_reg     = data[mcid_pkg::CFG_BITS-1:0];
      mcid_pkg::CFG_OFF_THRESH:  off_reg    = data[mcid_pkg::CFG_BITS-1:0];
      mcid_pkg::CFG_ENABLE_MASK: enable_reg = data[mcid_pkg::WORD_BITS-1:0];
      mcid_pkg::CFG_INVERT_MASK: invert_reg = data[mcid_pkg::WORD_BITS-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Byte registers get random upper bits, which the block must drop
  task automatic apply_settings(logic [mcid_pkg::CFG_BITS-1:0] lim,
                                logic [mcid_pkg::CFG_BITS-1:0] on_th,
                                logic [mcid_pkg::CFG_BITS-1:0] off_th,
                                logic [mcid_pkg::WORD_BITS-1:0] en,
                                logic [mcid_pkg::WORD_BITS-1:0] inv);
    put_reg(mcid_pkg::CFG_COUNT_LIMIT,
            {(mcid_pkg::CFG_DATA_BITS - mcid_pkg::CFG_BITS)'($urandom()), lim});
    put_reg(mcid_pkg::CFG_ON_THRESH,
            {(mcid_pkg::CFG_DATA_BITS - mcid_pkg::CFG_BITS)'($urandom()), on_th});
    put_reg(mcid_pkg::CFG_OFF_THRESH,
            {(mcid_pkg::CFG_DATA_BITS - mcid_pkg::CFG_BITS)'($urandom()), off_th});
    put_reg(mcid_pkg::CFG_ENABLE_MASK, en);
    put_reg(mcid_pkg::CFG_INVERT_MASK, inv);
    if ($urandom_range(0, 2) == 0) put_reg(CFG_IDX_UNUSED, rand_word());
    cfg_we_i <= 1'b0;
    settings_count++;
  endtask

  task automatic queue_pins(logic [mcid_pkg::WORD_BITS-1:0] pins);
    pending_pins.push_back(pins);
    queued_count++;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (accepted_count != queued_count || expected_filtered.size() != 0);
  endtask

  task automatic random_phase(int phase);
    int pct;
    if (phase == 1 || phase == 2) begin
      // drive counters towards the top of their range
      apply_settings(8'd255, 8'd255, 8'd0, '1, '0);
      base_pins = '1;
      pct = 3;
    end else if (phase == 3) begin
      // counters now sit above a much lower limit
      apply_settings(8'd10, 8'd5, 8'd2, '1, rand_word());
      base_pins = rand_word();
      pct = 10;
    end else begin
      apply_settings(pick_byte(), pick_byte(), pick_byte(), pick_mask(), pick_mask());
      base_pins = rand_word();
      pct = ($urandom_range(0, 2) == 0) ? 2 : 10;
    end
    for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
      if (phase > 3 && $urandom_range(0, 39) == 0) base_pins = rand_word();
      if ($urandom_range(0, 9) == 0) queue_pins(rand_word());
      else queue_pins(noisy_word(base_pins, pct));
    end
    wait_idle();
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Request side: mirror each accepted request in the predictor
  always @(posedge clk_i) begin
    in_fire = rst_ni && in_valid_i && in_ready_o;
    if (in_fire) begin
      expected_filtered.push_back(debounce_word(raw_pins_i));
      accepted_count++;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (pending_pins.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        raw_pins_i <= pending_pins.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side; hold ready low once for a long stretch to back the block up
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (!held_off && results_seen >= 200) begin
        hold_left <= HOLD_OFF_CYCLES;
        held_off <= 1'b1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    logic [mcid_pkg::WORD_BITS-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_filtered.size() == 0) begin
        $error("filtered_pins: unexpected result %h", filtered_pins_o);
        error_count++;
      end else begin
        want = expected_filtered.pop_front();
        if (filtered_pins_o !== want) begin
          $error("filtered_pins mismatch: expected %h, actual %h", want, filtered_pins_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = mcid_pkg::CFG_COUNT_LIMIT;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    raw_pins_i  = '0;
    out_ready_i = 1'b0;
    hold_left   = 0;
    held_off    = 1'b0;
    in_fire     = 1'b0;
    limit_reg   = mcid_pkg::RST_COUNT_LIMIT;
    on_reg      = mcid_pkg::RST_ON_THRESH;
    off_reg     = mcid_pkg::RST_OFF_THRESH;
    enable_reg  = mcid_pkg::RST_ENABLE_MASK;
    invert_reg  = mcid_pkg::RST_INVERT_MASK;
    for (int ch = 0; ch < mcid_pkg::CHANNELS; ch++) begin
      chan_count[ch] = '0;
      chan_level[ch] = 1'b0;
    end
    send_idle_pct = 18;
    recv_idle_pct = 59;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: channels 1-7 disabled, channels 0, 8-31, 38 and 39 inverted
    queue_pins('0);
    queue_pins('1);
    queue_pins(40'h55_5555_5555);
    queue_pins(40'hAA_AAAA_AAAA);
    queue_pins('0);
    wait_idle();

    // hysteresis between the two thresholds, saturation at the limit
    apply_settings(8'd4, 8'd3, 8'd1, '1, 40'hAA_AAAA_AAAA);
    repeat (5) queue_pins('1);
    repeat (3) queue_pins('0);
    repeat (4) queue_pins('1);
    wait_idle();

    // counters left above a lowered limit; zero on threshold
    apply_settings(8'd2, 8'd0, 8'd0, '1, '0);
    queue_pins('1);
    queue_pins('0);
    queue_pins('1);
    repeat (3) queue_pins('0);
    wait_idle();

    // zero limit, unreachable on threshold, part of the channels disabled
    apply_settings(8'd0, 8'd255, 8'd255, 40'h00_0000_FFFF, '1);
    queue_pins('1);
    queue_pins('0);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES / 3) begin
        send_idle_pct = 59;
        recv_idle_pct = 18;
      end else if (p == 2 * PHASES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_phase(p);
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Checked %0d filtered words from %0d requests across %0d settings.",
             results_seen, accepted_count, settings_count + 1);
    $display("Covered saturation, lowered limits, hysteresis, masks and a long output stall.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/mcid_pkg.sv
rtl/mcid_ram.sv
rtl/mcid_ctrl.sv
rtl/mcid_datapath.sv
rtl/multi_channel_integrating_debouncer.sv
tb/sv/multi_channel_integrating_debouncer_tb.sv
